FILE: design/bitmap_first_fit_allocator_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap first-fit allocator
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BFA_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bfa assertion failed");

// Next-cycle implication, disabled during reset.
`define BFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bfa assertion failed");

`endif

FILE: design/bfa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap first-fit allocator package
// Shared types, field widths and codes.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int WORD_BITS = 32;
  localparam int BYTES_W   = 21;
  localparam int BLOCK_W   = 15;
  localparam int RUN_W     = 16;
  localparam int NEED_W    = 17;
  localparam int STATUS_W  = 2;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN    = 2'd3;

  typedef struct packed {
    logic       all_free;
    logic [5:0] low_free;
    logic [5:0] high_free;
    logic       inner_hit;
    logic [4:0] inner_ofs;
  } word_info_t;

endpackage

FILE: design/bitmap_first_fit_allocator_top.sv
// An allocate scans the record table and then the used-bit map; a free scans only the
// record table. On success both then update the map word by word and write the record
// slot. A zero-size allocate skips the scans and goes straight to a no-space result.
// One request is in progress at a time and each scan reads one entry per cycle; a result
// still waiting on the output holds the next request in its last cycle. After reset a
// clearing pass over the map and the record table keeps the input closed.
// ----------------------------------------------------------------------------
// Bitmap first-fit allocator
// Allocates and frees runs of 32-byte blocks using a used-bit map and a
// table of allocation records, both held in synchronous RAM.
// ----------------------------------------------------------------------------
module bitmap_first_fit_allocator_top #(
  parameter int HEAP_BLOCKS  = 32768,
  parameter int RECORD_SLOTS = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // alloc_bytes[20:0], free_block[35:21], zero fill
  input  logic [bfa_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // kind[0]
  input  logic [0:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // start_block[14:0], run_blocks[30:15], zero fill
  output logic [bfa_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // status[1:0]
  output logic [bfa_pkg::STATUS_W-1:0]      m_axis_tuser
);
  import bfa_pkg::*;

  localparam int WORDS     = (HEAP_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int LAST_BITS = HEAP_BLOCKS - (WORDS - 1) * WORD_BITS;
  localparam int BW        = $clog2(HEAP_BLOCKS);
  localparam int WAW       = $clog2(WORDS);
  localparam int SW        = $clog2(RECORD_SLOTS);
  localparam int IW        = ((WAW > SW) ? WAW : SW) + 1;
  localparam int CW        = (((BW + 1) > NEED_W) ? (BW + 1) : NEED_W) + 1;
  localparam int RW        = BW + NEED_W;
  localparam int RCW       = (BW > BLOCK_W) ? BW : BLOCK_W;
  localparam logic [IW-1:0] CLR_LAST = IW'(((WORDS > RECORD_SLOTS) ? WORDS : RECORD_SLOTS) - 1);
  localparam logic [32:0] LOW_ONES = (33'd1 << LAST_BITS) - 33'd1;
  localparam logic [WORD_BITS-1:0] TAIL_MASK = ~LOW_ONES[WORD_BITS-1:0];

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_SCAN_REC = 3'd2;
  localparam logic [2:0] S_SCAN_MAP = 3'd3;
  localparam logic [2:0] S_MARK_RD  = 3'd4;
  localparam logic [2:0] S_MARK_WR  = 3'd5;
  localparam logic [2:0] S_REC_WR   = 3'd6;
  localparam logic [2:0] S_RESP     = 3'd7;

  logic [2:0]          state;
  logic                kind;
  logic [NEED_W-1:0]   need;
  logic [BLOCK_W-1:0]  fblk;
  logic [IW-1:0]       idx;
  logic [IW-1:0]       eidx;
  logic                pend;
  logic [SW-1:0]       slot;
  logic [BW:0]         run;
  logic [BW-1:0]       run_first;
  logic [NEED_W-1:0]   run_len;
  logic [WAW-1:0]      mw;
  logic [STATUS_W-1:0] res_status;
  logic [BLOCK_W-1:0]  res_start;
  logic [RUN_W-1:0]    res_len;

  logic                map_we;
  logic [WAW-1:0]      map_waddr;
  logic [WORD_BITS-1:0] map_wdata;
  logic [WAW-1:0]      map_raddr;
  logic [WORD_BITS-1:0] map_rdata;
  logic                rec_we;
  logic [SW-1:0]       rec_waddr;
  logic [RW-1:0]       rec_wdata;
  logic [RW-1:0]       rec_rdata;

  logic [WORD_BITS-1:0] eval_word;
  logic [5:0]           need_c;
  word_info_t           info;
  logic [CW-1:0]        carry_sum;
  logic                 carry_hit;
  logic [CW-1:0]        carry_first;
  logic [BW-1:0]        inner_first;
  logic [BW-1:0]        run_last;
  logic [WAW-1:0]       first_word;
  logic [WAW-1:0]       last_word;
  logic [4:0]           mask_lo;
  logic [4:0]           mask_hi;
  logic [WORD_BITS-1:0] word_mask;
  logic [BW-1:0]        rec_start;
  logic [NEED_W-1:0]    rec_len;
  logic                 rec_hit;
  logic [BYTES_W:0]     bytes_sum;

  assign bytes_sum = {1'b0, s_axis_tdata[BYTES_W-1:0]} + (BYTES_W+1)'(WORD_BITS - 1);

  bfa_ram #(.WIDTH(WORD_BITS), .DEPTH(WORDS), .AW(WAW)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  bfa_ram #(.WIDTH(RW), .DEPTH(RECORD_SLOTS), .AW(SW)) u_rec (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .raddr (idx[SW-1:0]),
    .rdata (rec_rdata)
  );

  assign eval_word = (eidx[WAW-1:0] == WAW'(WORDS - 1)) ? (map_rdata | TAIL_MASK) : map_rdata;
  assign need_c    = (need > NEED_W'(WORD_BITS)) ? 6'd33 : need[5:0];

  bfa_scan u_scan (
    .word (eval_word),
    .need (need_c),
    .info (info)
  );

  assign carry_sum   = CW'(run) + CW'(info.low_free);
  assign carry_hit   = carry_sum >= CW'(need);
  assign carry_first = (CW'(eidx[WAW-1:0]) << 5) - CW'(run);
  assign inner_first = BW'({eidx[WAW-1:0], info.inner_ofs});

  assign run_last   = BW'(CW'(run_first) + CW'(run_len) - CW'(1));
  assign first_word = WAW'(run_first[BW-1:5]);
  assign last_word  = WAW'(run_last[BW-1:5]);
  assign mask_lo    = (mw == first_word) ? run_first[4:0] : 5'd0;
  assign mask_hi    = (mw == last_word) ? run_last[4:0] : 5'd31;
  assign word_mask  = ({WORD_BITS{1'b1}} << mask_lo) & ({WORD_BITS{1'b1}} >> (5'd31 - mask_hi));

  assign rec_start = rec_rdata[RW-1:NEED_W];
  assign rec_len   = rec_rdata[NEED_W-1:0];
  assign rec_hit   = (kind == KIND_ALLOC) ? (rec_len == '0)
                   : ((rec_len != '0) && (RCW'(rec_start) == RCW'(fblk)));

  assign map_raddr = (state == S_SCAN_MAP) ? idx[WAW-1:0] : mw;

  always_comb begin
    map_we    = 1'b0;
    map_waddr = mw;
    map_wdata = '0;
    rec_we    = 1'b0;
    rec_waddr = slot;
    rec_wdata = '0;
    if (state == S_CLEAR) begin
      map_we    = idx < IW'(WORDS);
      map_waddr = idx[WAW-1:0];
      rec_we    = idx < IW'(RECORD_SLOTS);
      rec_waddr = idx[SW-1:0];
    end else if (state == S_MARK_WR) begin
      map_we    = 1'b1;
      map_wdata = (kind == KIND_ALLOC) ? (map_rdata | word_mask) : (map_rdata & ~word_mask);
    end else if (state == S_REC_WR) begin
      rec_we    = 1'b1;
      rec_wdata = (kind == KIND_ALLOC) ? {run_first, run_len} : '0;
    end
  end

  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      idx           <= '0;
      pend          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_RESP) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          idx <= idx + IW'(1);
          if (idx == CLR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            kind <= s_axis_tuser[0];
            need <= bytes_sum[BYTES_W:5];
            fblk <= s_axis_tdata[BYTES_W+BLOCK_W-1:BYTES_W];
            idx  <= '0;
            pend <= 1'b0;
            if (s_axis_tuser[0] == KIND_ALLOC && bytes_sum[BYTES_W:5] == '0) begin
              res_status <= ST_NO_SPACE;
              res_start  <= '0;
              res_len    <= '0;
              state      <= S_RESP;
            end else begin
              state <= S_SCAN_REC;
            end
          end
        end
        S_SCAN_REC: begin
          if (pend && rec_hit) begin
            slot <= eidx[SW-1:0];
            idx  <= '0;
            pend <= 1'b0;
            run  <= '0;
            if (kind == KIND_ALLOC) begin
              state <= S_SCAN_MAP;
            end else begin
              run_first <= rec_start;
              run_len   <= rec_len;
              mw        <= WAW'(rec_start[BW-1:5]);
              res_status <= ST_OK;
              res_start  <= '0;
              res_len    <= RUN_W'(rec_len);
              state      <= S_MARK_RD;
            end
          end else if (!pend && idx == IW'(RECORD_SLOTS)) begin
            res_status <= (kind == KIND_ALLOC) ? ST_TABLE_FULL : ST_UNKNOWN;
            res_start  <= '0;
            res_len    <= '0;
            state      <= S_RESP;
          end else begin
            pend <= idx < IW'(RECORD_SLOTS);
            eidx <= idx;
            if (idx < IW'(RECORD_SLOTS)) begin
              idx <= idx + IW'(1);
            end
          end
        end
        S_SCAN_MAP: begin
          if (pend && (carry_hit || info.inner_hit)) begin
            run_first  <= carry_hit ? BW'(carry_first) : inner_first;
            run_len    <= need;
            mw         <= carry_hit ? WAW'(carry_first[BW-1:5]) : eidx[WAW-1:0];
            res_status <= ST_OK;
            res_start  <= BLOCK_W'(carry_hit ? BW'(carry_first) : inner_first);
            res_len    <= RUN_W'(need);
            state      <= S_MARK_RD;
          end else if (!pend && idx == IW'(WORDS)) begin
            res_status <= ST_NO_SPACE;
            res_start  <= '0;
            res_len    <= '0;
            state      <= S_RESP;
          end else begin
            if (pend) begin
              run <= info.all_free ? (run + (BW+1)'(WORD_BITS)) : (BW+1)'(info.high_free);
            end
            pend <= idx < IW'(WORDS);
            eidx <= idx;
            if (idx < IW'(WORDS)) begin
              idx <= idx + IW'(1);
            end
          end
        end
        S_MARK_RD: begin
          state <= S_MARK_WR;
        end
        S_MARK_WR: begin
          if (mw == last_word) begin
            state <= S_REC_WR;
          end else begin
            mw    <= mw + WAW'(1);
            state <= S_MARK_RD;
          end
        end
        S_REC_WR: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= res_status;
            m_axis_tdata  <= {1'b0, res_len, res_start};
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/bfa_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/bfa_scan.sv
// ----------------------------------------------------------------------------
// Used-bit word evaluator
// Finds the free prefix, the free suffix and the lowest free run of the
// requested length inside one 32-bit word of the map.
// ----------------------------------------------------------------------------
module bfa_scan (
  input  logic [bfa_pkg::WORD_BITS-1:0] word,
  input  logic [5:0]                    need,
  output bfa_pkg::word_info_t           info
);
  import bfa_pkg::*;

  logic [63:0] pat;
  logic [63:0] sh;

  always_comb begin
    info = '0;
    info.all_free  = (word == '0);
    info.low_free  = 6'd32;
    info.high_free = 6'd32;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (word[i]) begin
        info.low_free = 6'(i);
      end
    end
    for (int i = 0; i < WORD_BITS; i++) begin
      if (word[i]) begin
        info.high_free = 6'(WORD_BITS - 1 - i);
      end
    end
    pat = (64'd1 << need) - 64'd1;
    for (int p = WORD_BITS - 1; p >= 0; p--) begin
      sh = pat << p;
      if (sh[63:32] == '0 && (word & sh[31:0]) == '0) begin
        info.inner_hit = 1'b1;
        info.inner_ofs = 5'(p);
      end
    end
  end

endmodule

FILE: design/bfa_checker.sv
// ----------------------------------------------------------------------------
// Bitmap first-fit allocator port checker
// Watches the top-level ports and is bound to every instance of the top.
// ----------------------------------------------------------------------------
`include "bitmap_first_fit_allocator_top_macros.svh"

module bfa_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [bfa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [bfa_pkg::STATUS_W-1:0]   m_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready
);
  import bfa_pkg::*;

  // A stalled result transfer keeps its payload.
  `BFA_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  // The clearing pass keeps the input closed right after reset.
  `BFA_ASSERT_SAME(a_clear_closed, clk, rst, $fell(rst), !s_axis_tready)
  // Only one request is in progress at a time.
  `BFA_ASSERT_NEXT(a_one_at_a_time, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // An error result carries no block number and no length.
  `BFA_ASSERT_SAME(a_err_zero, clk, rst, m_axis_tvalid && m_axis_tuser != ST_OK, m_axis_tdata == '0)

endmodule

bind bitmap_first_fit_allocator_top bfa_checker u_bfa_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
